// ===== design/mi3_pkg.sv =====
// Package for the 3x3 matrix inverse core: payload structs, widths and cofactor tables.
// Used by matrix_inverse_3x3_core and mi3_checker; depends on nothing.
`default_nettype none

package mi3_pkg;

    // Fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int FRAC_BITS_MAX     = 30;

    localparam int ELEM_W = 32;                       // matrix element
    localparam int THR_W  = 31;                       // singular threshold
    localparam int PROD_W = 2 * ELEM_W;               // element product
    localparam int COF_W  = PROD_W + 2;               // signed cofactor
    localparam int CMAG_W = PROD_W;                   // cofactor magnitude, at most 2^63
    localparam int DEN_W  = CMAG_W + ELEM_W;          // determinant magnitude, below 2^96
    localparam int DET_W  = DEN_W + 2;                // signed determinant
    localparam int Q_W    = ELEM_W + 1;               // quotient bits before rounding
    localparam int REM_W  = DEN_W + Q_W + 1;          // division remainder
    localparam int NUM_W  = CMAG_W + 2 * FRAC_BITS_MAX;

    localparam logic [Q_W:0] POS_LIMIT = (Q_W + 1)'(32'h7FFF_FFFF);
    localparam logic [Q_W:0] NEG_LIMIT = (Q_W + 1)'(32'h8000_0000);
    localparam logic [ELEM_W-1:0] POS_SAT = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] NEG_SAT = 32'h8000_0000;

    // Cofactor k = sign * (m[i0]*m[i1] - m[i2]*m[i3]), index 3*row + col.
    localparam int COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{3, 8, 5, 6}, '{3, 7, 4, 6},
        '{1, 8, 2, 7}, '{0, 8, 2, 6}, '{0, 7, 1, 6},
        '{1, 5, 2, 4}, '{0, 5, 2, 3}, '{0, 4, 1, 3}
    };
    localparam bit COF_NEG [9] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};

    // Output element k takes the transposed cofactor.
    localparam int ADJ [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    typedef struct packed {
        logic signed [ELEM_W-1:0] a00;
        logic signed [ELEM_W-1:0] a01;
        logic signed [ELEM_W-1:0] a02;
        logic signed [ELEM_W-1:0] a10;
        logic signed [ELEM_W-1:0] a11;
        logic signed [ELEM_W-1:0] a12;
        logic signed [ELEM_W-1:0] a20;
        logic signed [ELEM_W-1:0] a21;
        logic signed [ELEM_W-1:0] a22;
    } matrix_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] b00;
        logic signed [ELEM_W-1:0] b01;
        logic signed [ELEM_W-1:0] b02;
        logic signed [ELEM_W-1:0] b10;
        logic signed [ELEM_W-1:0] b11;
        logic signed [ELEM_W-1:0] b12;
        logic signed [ELEM_W-1:0] b20;
        logic signed [ELEM_W-1:0] b21;
        logic signed [ELEM_W-1:0] b22;
        logic                     singular;
    } inverse_t;

endpackage

`default_nettype wire

// ===== design/matrix_inverse_3x3_core.sv =====
// 3x3 matrix inverse by adjugate in signed fixed point, fully pipelined.
// Depends on mi3_pkg for the payload structs, widths and cofactor tables.
`default_nettype none

// The core takes one matrix in every clock cycle: busy never rises, so every start
// is a request taken at once. Each result appears on inverse with done high for one
// cycle; results leave in request order. The stages are those of products, cofactors
// and determinant, a load with the singular and overflow checks, then 33 restoring
// division stages (one quotient bit each, nine lanes side by side), one rounding
// stage and the output register. A write to the threshold is taken in any cycle and
// applies to matrices that reach the threshold compare afterwards, so write it only
// while no request is in flight. There is no clearing pass after reset.
module matrix_inverse_3x3_core #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output      logic                     busy,
    input  wire mi3_pkg::matrix_t         matrix,
    output      logic                     done,
    output      mi3_pkg::inverse_t        inverse,
    input  wire logic                     cfg_valid,
    output      logic                     cfg_ready,
    input  wire logic [mi3_pkg::THR_W-1:0] cfg_data
);

    localparam int EW  = mi3_pkg::ELEM_W;
    localparam int QW  = mi3_pkg::Q_W;
    localparam int RW  = mi3_pkg::REM_W;
    localparam int DW  = mi3_pkg::DEN_W;
    localparam int SW  = mi3_pkg::DET_W;
    localparam int CW  = mi3_pkg::COF_W;
    localparam int MW  = mi3_pkg::CMAG_W;
    localparam int PW  = mi3_pkg::PROD_W;
    localparam int HW  = MW / 2;

    // Threshold register and handshake outputs.
    logic [mi3_pkg::THR_W-1:0] thr_reg;
    logic                      accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= mi3_pkg::THR_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Unpack the request into an indexed view.
    logic signed [EW-1:0] m [9];

    assign m[0] = matrix.a00;
    assign m[1] = matrix.a01;
    assign m[2] = matrix.a02;
    assign m[3] = matrix.a10;
    assign m[4] = matrix.a11;
    assign m[5] = matrix.a12;
    assign m[6] = matrix.a20;
    assign m[7] = matrix.a21;
    assign m[8] = matrix.a22;

    // Stage registers.
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [PW-1:0] p1_reg [9];
    logic signed [PW-1:0] q1_reg [9];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [CW-1:0] c2_reg [9];
    logic signed [EW-1:0] e2_reg [3];
    logic [MW-1:0]        cm3_reg [9];
    logic                 cs3_reg [9];
    logic [EW-1:0]        em3_reg [3];
    logic                 es3_reg [3];
    logic [PW-1:0]        plo4_reg [3];
    logic [PW-1:0]        phi4_reg [3];
    logic                 ts4_reg [3];
    logic [MW-1:0]        cm4_reg [9];
    logic                 cs4_reg [9];
    logic signed [SW-1:0] t5_reg [3];
    logic [MW-1:0]        cm5_reg [9];
    logic                 cs5_reg [9];
    logic signed [SW-1:0] det6_reg;
    logic [MW-1:0]        cm6_reg [9];
    logic                 cs6_reg [9];
    logic [DW-1:0]        dm7_reg;
    logic                 ds7_reg;
    logic [MW-1:0]        cm7_reg [9];
    logic                 cs7_reg [9];

    // Division chain, index 0 is the loaded numerator.
    logic [RW-1:0]        rem_reg  [0:QW][9];
    logic [QW-1:0]        quo_reg  [0:QW][9];
    logic                 neg_reg  [0:QW][9];
    logic                 ovf_reg  [0:QW][9];
    logic [DW-1:0]        den_reg  [0:QW];
    logic                 sing_reg [0:QW];
    logic                 vd_reg   [0:QW];

    // Rounding stage and output.
    logic [QW:0]          qr_reg [9];
    logic                 nr_reg [9];
    logic                 or_reg [9];
    logic                 sr_reg;
    logic                 vr_reg;
    logic                 done_reg;
    mi3_pkg::inverse_t    out_reg;
    mi3_pkg::inverse_t    out_next;
    logic [EW-1:0]        val [9];

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            vr_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int s = 0; s <= QW; s++)
            begin
                vd_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            vd_reg[0] <= v7_reg;
            for (int s = 0; s < QW; s++)
            begin
                vd_reg[s+1] <= vd_reg[s];
            end
            vr_reg   <= vd_reg[QW];
            done_reg <= vr_reg;
        end
    end

    // Front end: products, cofactors, magnitudes and the determinant.
    always_ff @(posedge clk)
    begin
        // Element products.
        for (int k = 0; k < 9; k++)
        begin
            p1_reg[k] <= m[mi3_pkg::COF_IDX[k][0]] * m[mi3_pkg::COF_IDX[k][1]];
            q1_reg[k] <= m[mi3_pkg::COF_IDX[k][2]] * m[mi3_pkg::COF_IDX[k][3]];
        end
        for (int j = 0; j < 3; j++)
        begin
            e1_reg[j] <= m[j];
        end

        // Signed cofactors.
        for (int k = 0; k < 9; k++)
        begin
            if (mi3_pkg::COF_NEG[k])
            begin
                c2_reg[k] <= CW'(q1_reg[k]) - CW'(p1_reg[k]);
            end
            else
            begin
                c2_reg[k] <= CW'(p1_reg[k]) - CW'(q1_reg[k]);
            end
        end
        e2_reg <= e1_reg;

        // Sign and magnitude split.
        for (int k = 0; k < 9; k++)
        begin
            cs3_reg[k] <= c2_reg[k][CW-1];
            cm3_reg[k] <= MW'(c2_reg[k][CW-1] ? -c2_reg[k] : c2_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            es3_reg[j] <= e2_reg[j][EW-1];
            em3_reg[j] <= EW'(e2_reg[j][EW-1] ? -e2_reg[j] : e2_reg[j]);
        end

        // First-row expansion terms as two half products each.
        for (int j = 0; j < 3; j++)
        begin
            plo4_reg[j] <= em3_reg[j] * cm3_reg[j][HW-1:0];
            phi4_reg[j] <= em3_reg[j] * cm3_reg[j][MW-1:HW];
            ts4_reg[j]  <= es3_reg[j] ^ cs3_reg[j];
        end
        cm4_reg <= cm3_reg;
        cs4_reg <= cs3_reg;

        // Recombine halves and apply the term sign.
        for (int j = 0; j < 3; j++)
        begin
            if (ts4_reg[j])
            begin
                t5_reg[j] <= -SW'((DW'(phi4_reg[j]) << HW) + DW'(plo4_reg[j]));
            end
            else
            begin
                t5_reg[j] <= SW'((DW'(phi4_reg[j]) << HW) + DW'(plo4_reg[j]));
            end
        end
        cm5_reg <= cm4_reg;
        cs5_reg <= cs4_reg;

        // Determinant.
        det6_reg <= t5_reg[0] + t5_reg[1] + t5_reg[2];
        cm6_reg  <= cm5_reg;
        cs6_reg  <= cs5_reg;

        // Determinant magnitude.
        ds7_reg <= det6_reg[SW-1];
        dm7_reg <= DW'(det6_reg[SW-1] ? -det6_reg : det6_reg);
        cm7_reg <= cm6_reg;
        cs7_reg <= cs6_reg;
    end

    // Division: load numerators, singular and overflow checks, then one bit per stage.
    always_ff @(posedge clk)
    begin
        den_reg[0]  <= dm7_reg;
        sing_reg[0] <= dm7_reg <= (DW'(thr_reg) << (2 * FRAC_BITS));
        for (int k = 0; k < 9; k++)
        begin
            rem_reg[0][k] <= RW'(cm7_reg[mi3_pkg::ADJ[k]]) << (2 * FRAC_BITS);
            quo_reg[0][k] <= '0;
            neg_reg[0][k] <= cs7_reg[mi3_pkg::ADJ[k]] ^ ds7_reg;
            ovf_reg[0][k] <= (RW'(cm7_reg[mi3_pkg::ADJ[k]]) << (2 * FRAC_BITS))
                             >= (RW'(dm7_reg) << QW);
        end

        for (int s = 0; s < QW; s++)
        begin
            den_reg[s+1]  <= den_reg[s];
            sing_reg[s+1] <= sing_reg[s];
            for (int k = 0; k < 9; k++)
            begin
                if (rem_reg[s][k] >= (RW'(den_reg[s]) << (QW - 1 - s)))
                begin
                    rem_reg[s+1][k] <= rem_reg[s][k] - (RW'(den_reg[s]) << (QW - 1 - s));
                    quo_reg[s+1][k] <= {quo_reg[s][k][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1][k] <= rem_reg[s][k];
                    quo_reg[s+1][k] <= {quo_reg[s][k][QW-2:0], 1'b0};
                end
                neg_reg[s+1][k] <= neg_reg[s][k];
                ovf_reg[s+1][k] <= ovf_reg[s][k];
            end
        end

        // Round to nearest, ties away from zero.
        for (int k = 0; k < 9; k++)
        begin
            qr_reg[k] <= (QW + 1)'(quo_reg[QW][k])
                         + (QW + 1)'({rem_reg[QW][k][RW-2:0], 1'b0} >= RW'(den_reg[QW]));
            nr_reg[k] <= neg_reg[QW][k];
            or_reg[k] <= ovf_reg[QW][k];
        end
        sr_reg <= sing_reg[QW];

        out_reg <= out_next;
    end

    // Saturate, apply sign, or substitute the identity.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            if (sr_reg)
            begin
                val[k] = (k % 4 == 0) ? (EW'(1) << FRAC_BITS) : '0;
            end
            else if (nr_reg[k])
            begin
                if (or_reg[k] || qr_reg[k] > mi3_pkg::NEG_LIMIT)
                begin
                    val[k] = mi3_pkg::NEG_SAT;
                end
                else
                begin
                    val[k] = EW'(-qr_reg[k]);
                end
            end
            else
            begin
                if (or_reg[k] || qr_reg[k] > mi3_pkg::POS_LIMIT)
                begin
                    val[k] = mi3_pkg::POS_SAT;
                end
                else
                begin
                    val[k] = EW'(qr_reg[k]);
                end
            end
        end
        out_next.b00      = val[0];
        out_next.b01      = val[1];
        out_next.b02      = val[2];
        out_next.b10      = val[3];
        out_next.b11      = val[4];
        out_next.b12      = val[5];
        out_next.b20      = val[6];
        out_next.b21      = val[7];
        out_next.b22      = val[8];
        out_next.singular = sr_reg;
    end

    assign done    = done_reg;
    assign inverse = out_reg;

endmodule

`default_nettype wire

// ===== design/mi3_checker.sv =====
// Port-level checks for matrix_inverse_3x3_core, attached by the bind at the end.
// Depends on mi3_pkg for the payload structs.
`default_nettype none

module mi3_assertions #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEFAULT
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire mi3_pkg::matrix_t          matrix,
    input wire logic                      done,
    input wire mi3_pkg::inverse_t         inverse,
    input wire logic                      cfg_valid,
    input wire logic                      cfg_ready,
    input wire logic [mi3_pkg::THR_W-1:0] cfg_data
);

    localparam logic [mi3_pkg::ELEM_W-1:0] ONE = mi3_pkg::ELEM_W'(1) << FRAC_BITS;

    // The pipeline takes a request in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("core reported busy");

    // A singular result carries ones on the diagonal.
    a_sing_diag: assert property (@(posedge clk) disable iff (!rst_n)
        done && inverse.singular |->
            inverse.b00 == ONE && inverse.b11 == ONE && inverse.b22 == ONE)
        else $error("singular result without unit diagonal");

    // A singular result carries zeros off the diagonal.
    a_sing_off: assert property (@(posedge clk) disable iff (!rst_n)
        done && inverse.singular |->
            inverse.b01 == 0 && inverse.b02 == 0 && inverse.b10 == 0 &&
            inverse.b12 == 0 && inverse.b20 == 0 && inverse.b21 == 0)
        else $error("singular result with non-zero off-diagonal");

endmodule

bind matrix_inverse_3x3_core mi3_assertions #(.FRAC_BITS(FRAC_BITS)) u_mi3_assertions (.*);

`default_nettype wire
